// ===== hw/rtl/tcf_pkg.sv =====
// Shared types, constants and helper functions for the tilt complementary filter.
// Used by tcf_mac, tcf_ctrl and tilt_complementary_filter_unit; no dependencies.
package tcf_pkg;

	localparam int SAMPLE_W = 32;
	localparam int OP_A_W   = SAMPLE_W + 1;      // sample difference/sum needs one extra bit
	localparam int OP_B_W   = 18;                // signed coefficient, covers 0..65535 and -1
	localparam int ACC_W    = SAMPLE_W + OP_B_W; // 33x18 product and sums fit in here
	localparam int REG_W    = 16;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int ALPHA_ONE     = 32768;
	localparam int ALPHA_RESET   = 32113;
	localparam int PERIOD_RESET  = 1311;
	localparam int ROOT_HALF_Q15 = 23170;
	localparam int ROUND_Q15     = 16384;
	localparam int Q15_SHIFT     = 15;
	localparam int Q16_SHIFT     = 16;

	localparam logic REG_ALPHA  = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_RATE_A,
		ST_SUM,
		ST_RATE_B,
		ST_INC,
		ST_PRED,
		ST_MIX_P,
		ST_MIX_M,
		ST_FIN
	} step_t;

	typedef struct packed {
		step_t step;
		logic  ax;       // 0: first tilt axis, 1: second
		logic  fin_go;   // result register loaded this cycle
	} ctrl_t;

	typedef struct packed {
		logic                       restart;
		logic signed [SAMPLE_W-1:0] in_position;
		logic signed [SAMPLE_W-1:0] in_angle_a;
		logic signed [SAMPLE_W-1:0] in_angle_b;
		logic signed [SAMPLE_W-1:0] in_rate_x;
		logic signed [SAMPLE_W-1:0] in_rate_y;
		logic signed [SAMPLE_W-1:0] in_rate_z;
		logic signed [SAMPLE_W-1:0] in_aux_one;
		logic signed [SAMPLE_W-1:0] in_aux_two;
		logic signed [SAMPLE_W-1:0] in_aux_three;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_position;
		logic signed [SAMPLE_W-1:0] out_angle_a;
		logic signed [SAMPLE_W-1:0] out_angle_b;
		logic signed [SAMPLE_W-1:0] out_rate_x;
		logic signed [SAMPLE_W-1:0] out_rate_y;
		logic signed [SAMPLE_W-1:0] out_rate_z;
		logic signed [SAMPLE_W-1:0] out_aux_one;
		logic signed [SAMPLE_W-1:0] out_aux_two;
		logic signed [SAMPLE_W-1:0] out_aux_three;
	} result_t;

	function automatic logic signed [OP_A_W-1:0] ext_a(input logic signed [SAMPLE_W-1:0] x);
		return {x[SAMPLE_W-1], x};
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_c(input logic signed [SAMPLE_W-1:0] x);
		return {{(ACC_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_w(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return hi[SAMPLE_W-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_W-1:0];
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/tcf_mac.sv =====
// Shared multiply-accumulate unit: acc <= a * b + c, registered.
// Depends on tcf_pkg for operand widths.
module tcf_mac import tcf_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [OP_A_W-1:0] a,
	input  logic signed [OP_B_W-1:0] b,
	input  logic signed [ACC_W-1:0]  c,
	output logic signed [ACC_W-1:0]  acc
);

	logic signed [OP_A_W+OP_B_W-1:0] prod;
	logic signed [ACC_W-1:0]         acc_q;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= prod[ACC_W-1:0] + c;
		end
	end

	assign acc = acc_q;

endmodule

// ===== hw/rtl/tcf_ctrl.sv =====
// Step sequencer for the filter: walks the MAC through rate, predict and blend steps.
// Depends on tcf_pkg for step_t and ctrl_t.
module tcf_ctrl import tcf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,      // sample transfer this cycle
	input  logic  load_only,  // first or restart sample: no arithmetic
	input  logic  out_free,
	output ctrl_t ctrl
);

	step_t state_q, state_d;
	logic  ax_q, ax_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ax_d        = ax_q;
		ctrl.fin_go = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ax_d = 1'b0;
				if (start) begin
					state_d = load_only ? ST_FIN : ST_DIFF;
				end
			end
			ST_DIFF:   state_d = ST_RATE_A;
			ST_RATE_A: state_d = ST_SUM;
			ST_SUM:    state_d = ST_RATE_B;
			ST_RATE_B: state_d = ST_INC;
			ST_INC:    state_d = ST_PRED;
			ST_PRED:   state_d = ST_MIX_P;
			ST_MIX_P:  state_d = ST_MIX_M;
			ST_MIX_M: begin
				if (ax_q) begin
					state_d = ST_FIN;
				end else begin
					ax_d    = 1'b1;
					state_d = ST_INC;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					ctrl.fin_go = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		ctrl.step = state_q;
		ctrl.ax   = ax_q;
	end

endmodule

// ===== hw/rtl/tilt_complementary_filter_unit.sv =====
// Top level of the two-axis tilt complementary filter: APB registers, sample and
// result registers, operand selection. Depends on tcf_pkg, tcf_mac and tcf_ctrl.
//
// Usage:
//   sample/sample_valid/sample_ready carry one sample vector per transfer;
//   result/result_valid/result_ready carry one result per sample, in order.
//   alpha (0x0) and sample_period (0x4) are to be written over the APB port while
//   idle; the unit itself does not enforce this.
// Timing:
//   The single multiply-accumulate unit works a normal sample in 12 dependent
//   steps (rates, then predict and blend for each axis), then a finish step.
//   A first or restart sample only reloads the estimates and goes straight to
//   the finish step. While a sample is being worked on sample_ready is low,
//   so the next sample is taken only once the previous one has left its
//   finish step.
// Reset:
//   arst_n clears the sequencer, estimates go to zero, the next sample is
//   treated as a first sample, and the registers return to their defaults.
// Stall:
//   A result waiting on result_ready is held in the output register; the unit
//   takes and works on the next sample meanwhile and holds it in its finish
//   step until the output register is free.
module tilt_complementary_filter_unit import tcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  sample_t           sample,
	input  logic              sample_valid,
	output logic              sample_ready,
	output result_t           result,
	output logic              result_valid,
	input  logic              result_ready
);

	logic [REG_W-1:0] alpha_q;
	logic [REG_W-1:0] period_q;
	logic [REG_W:0]   alpha_c;
	logic [REG_W:0]   alpha_inv;
	logic             cfg_wr;

	sample_t                    in_q;
	logic                       pass_q;
	logic                       first_q;
	logic signed [SAMPLE_W-1:0] est_a_q;
	logic signed [SAMPLE_W-1:0] est_b_q;
	logic signed [SAMPLE_W-1:0] rate_a_q;
	logic signed [SAMPLE_W-1:0] rate_b_q;
	result_t                    result_q;
	logic                       result_valid_q;

	ctrl_t                      ctrl;
	logic                       sample_fire;
	logic                       load_only;
	logic                       out_free;
	logic                       mac_en;
	logic signed [OP_A_W-1:0]   op_a;
	logic signed [OP_B_W-1:0]   op_b;
	logic signed [ACC_W-1:0]    op_c;
	logic signed [ACC_W-1:0]    acc;
	logic signed [SAMPLE_W-1:0] blend;

	// configuration registers
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PERIOD) ? {{(APB_DW-REG_W){1'b0}}, period_q}
	                                         : {{(APB_DW-REG_W){1'b0}}, alpha_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= REG_W'(ALPHA_RESET);
			period_q <= REG_W'(PERIOD_RESET);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ALPHA) begin
				alpha_q <= pwdata[REG_W-1:0];
			end else begin
				period_q <= pwdata[REG_W-1:0];
			end
		end
	end

	// weights above one act as one
	assign alpha_c   = ({1'b0, alpha_q} > (REG_W+1)'(ALPHA_ONE)) ? (REG_W+1)'(ALPHA_ONE)
	                                                             : {1'b0, alpha_q};
	assign alpha_inv = (REG_W+1)'(ALPHA_ONE) - alpha_c;

	// handshakes
	assign sample_ready = (ctrl.step == ST_IDLE);
	assign sample_fire  = sample_valid & sample_ready;
	assign load_only    = first_q | sample.restart;
	assign out_free     = ~result_valid_q | result_ready;

	tcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sample_fire),
		.load_only (load_only),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	// operand selection for the shared unit
	always_comb begin
		mac_en = 1'b1;
		op_a   = '0;
		op_b   = '0;
		op_c   = '0;
		case (ctrl.step)
			ST_DIFF: begin
				op_a = ext_a(in_q.in_rate_x);
				op_b = {OP_B_W{1'b1}};
				op_c = ext_c(in_q.in_rate_y);
			end
			ST_RATE_A: begin
				op_a = acc[OP_A_W-1:0];
				op_b = OP_B_W'(ROOT_HALF_Q15);
				op_c = ACC_W'(ROUND_Q15);
			end
			ST_SUM: begin
				op_a = ext_a(in_q.in_rate_x);
				op_b = OP_B_W'(1);
				op_c = ext_c(in_q.in_rate_y);
			end
			ST_RATE_B: begin
				// floor half of the rate sum, negated, plus the third rate
				op_a = ext_a(acc[SAMPLE_W:1]);
				op_b = {OP_B_W{1'b1}};
				op_c = ext_c(in_q.in_rate_z);
			end
			ST_INC: begin
				op_a = ext_a(ctrl.ax ? rate_b_q : rate_a_q);
				op_b = {{(OP_B_W-REG_W){1'b0}}, period_q};
				op_c = '0;
			end
			ST_PRED: begin
				op_a = ext_a(acc[Q16_SHIFT +: SAMPLE_W]);
				op_b = OP_B_W'(1);
				op_c = ext_c(ctrl.ax ? est_b_q : est_a_q);
			end
			ST_MIX_P: begin
				op_a = ext_a(sat_w(acc));
				op_b = {{(OP_B_W-REG_W-1){1'b0}}, alpha_c};
				op_c = ACC_W'(ROUND_Q15);
			end
			ST_MIX_M: begin
				op_a = ext_a(ctrl.ax ? in_q.in_angle_b : in_q.in_angle_a);
				op_b = {{(OP_B_W-REG_W-1){1'b0}}, alpha_inv};
				op_c = acc;
			end
			default: mac_en = 1'b0;
		endcase
	end

	tcf_mac u_mac (
		.clk (clk),
		.en  (mac_en),
		.a   (op_a),
		.b   (op_b),
		.c   (op_c),
		.acc (acc)
	);

	assign blend = sat_w(acc >>> Q15_SHIFT);

	// sample register
	always_ff @(posedge clk) begin
		if (sample_fire) begin
			in_q   <= sample;
			pass_q <= load_only;
		end
	end

	// intermediate rates
	always_ff @(posedge clk) begin
		if (ctrl.step == ST_SUM) begin
			rate_a_q <= blend;
		end
		if (ctrl.step == ST_INC && !ctrl.ax) begin
			rate_b_q <= sat_w(acc);
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			est_a_q <= '0;
			est_b_q <= '0;
		end else begin
			if (sample_fire) begin
				first_q <= 1'b0;
				if (load_only) begin
					est_a_q <= sample.in_angle_a;
					est_b_q <= sample.in_angle_b;
				end
			end
			if (ctrl.step == ST_INC && ctrl.ax) begin
				est_a_q <= blend;
			end
			if (ctrl.fin_go && !pass_q) begin
				est_b_q <= blend;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.fin_go) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin_go) begin
			result_q.out_position  <= pass_q ? in_q.in_position : '0;
			result_q.out_angle_a   <= pass_q ? in_q.in_angle_a : est_a_q;
			result_q.out_angle_b   <= pass_q ? in_q.in_angle_b : blend;
			result_q.out_rate_x    <= in_q.in_rate_x;
			result_q.out_rate_y    <= in_q.in_rate_y;
			result_q.out_rate_z    <= in_q.in_rate_z;
			result_q.out_aux_one   <= in_q.in_aux_one;
			result_q.out_aux_two   <= in_q.in_aux_two;
			result_q.out_aux_three <= in_q.in_aux_three;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// a transfer always leaves the unit busy in the cycle after it
	a_busy_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		sample_fire |=> !sample_ready)
		else $error("sample_ready high right after a sample transfer");

	// a finished result always lands in the output register
	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin_go |=> result_valid)
		else $error("finish step did not raise result_valid");

	// estimates hold while the unit is idle and no sample is offered
	a_est_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ready && !sample_valid) |=> ($stable(est_a_q) && $stable(est_b_q)))
		else $error("estimate changed while idle");

	// the finish step never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !ctrl.fin_go)
		else $error("result register overwritten while stalled");

endmodule
